// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile away under
// synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/ppcs_pkg.sv
// ----------------------------------------------------------------------------
// ppcs_pkg
// Shared types and constants of the path proximity conflict scan.
// ----------------------------------------------------------------------------
`default_nettype none

package ppcs_pkg;

  // Default own path capacity.
  localparam int MAX_WAYPOINTS_DEF = 256;

  // Coordinate, radius and result field widths.
  localparam int COORD_BITS = 16;
  localparam int RADIUS_W   = 16;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int VID_W      = 4;
  localparam int IDX_OUT_W  = 8;
  localparam int POS_W      = 8;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_CHECK  = 2'd2;

  typedef struct packed {
    logic        [1:0]            mode;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic        [VID_W-1:0]      vehicle_id;
    logic                         path_end;
  } ppcs_in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] own_index;
    logic [VID_W-1:0]     other_vehicle;
    logic [POS_W-1:0]     other_safe_index;
  } ppcs_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } ppcs_wp_t;

endpackage

`default_nettype wire

// File: rtl/path_proximity_conflict_scan.sv
// ----------------------------------------------------------------------------
// path_proximity_conflict_scan
// Holds one vehicle's own waypoint path and checks waypoints of other paths
// against it, reporting the first own waypoint within the alert radius.
// ----------------------------------------------------------------------------
// Clear, append, path-end and short-path items complete when accepted. A scanning
// item that hits strobes a result once its read has passed the read, distance and
// result registers; one without a hit holds busy until its last read returns.
// Throughput is one own waypoint per cycle, set by the single memory read
// port feeding the one distance pipeline. The receiver cannot stall.
// Reset (synchronous, rst_n low) clears the count, position and radius.
`default_nettype none

`include "assert_macros.svh"

module path_proximity_conflict_scan #(
  parameter int MAX_WAYPOINTS = ppcs_pkg::MAX_WAYPOINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Item input: taken when start is high and busy is low.
  input  wire logic                          start,
  output logic                               busy,
  input  wire ppcs_pkg::ppcs_in_t            in_item,
  // Result output: valid for exactly the cycle out_strobe is high.
  output logic                               out_strobe,
  output ppcs_pkg::ppcs_out_t                out_item,
  // Radius register write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ppcs_pkg::RADIUS_W-1:0] cfg_data
);
  import ppcs_pkg::*;

  localparam int IDX_W = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

  // The sequencer is idle between items and scans while a check item walks
  // the own path.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   own_count_r, own_count_nxt;
  logic [POS_W-1:0]   other_pos_r, other_pos_nxt;
  logic [R2_W-1:0]    r2_r;
  logic               issue_on_r, issue_on_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   last_idx_r, last_idx_nxt;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               out_strobe_r, out_strobe_nxt;
  ppcs_out_t          out_item_r, out_item_nxt;

  // Per-item payload latched at acceptance of a check item.
  ppcs_wp_t           pt_r, pt_nxt;
  logic [VID_W-1:0]   vid_r, vid_nxt;
  logic [POS_W-1:0]   safe_r, safe_nxt;

  logic               accept;
  logic               mem_we;
  logic               mem_re;
  logic               flush;
  ppcs_wp_t           wp_in;
  ppcs_wp_t           mem_rdata;
  logic               dist_vld;
  logic               dist_hit;
  logic [IDX_W-1:0]   dist_idx;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  assign wp_in.x = in_item.pos_x;
  assign wp_in.y = in_item.pos_y;
  assign wp_in.z = in_item.pos_z;

  // Command decode and scan sequencing. Reads are issued for own indexes
  // 0 through own_count-2; the distance unit returns them in order, so the
  // first hit to come back is the first one in path order. A hit flushes
  // whatever is still in flight behind it.
  always_comb begin
    state_nxt      = state_r;
    own_count_nxt  = own_count_r;
    other_pos_nxt  = other_pos_r;
    issue_on_nxt   = issue_on_r;
    k_nxt          = k_r;
    last_idx_nxt   = last_idx_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    pt_nxt         = pt_r;
    vid_nxt        = vid_r;
    safe_nxt       = safe_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    flush          = 1'b0;

    if (accept) begin
      case (in_item.mode)
        MODE_CLEAR: begin
          own_count_nxt = '0;
          other_pos_nxt = '0;
        end
        MODE_APPEND: begin
          // A full path ignores further appends.
          if (own_count_r < CNT_W'(MAX_WAYPOINTS)) begin
            mem_we        = 1'b1;
            own_count_nxt = own_count_r + CNT_W'(1);
          end
        end
        MODE_CHECK: begin
          if (in_item.path_end) begin
            // The last waypoint of a path is not checked; its counter restarts.
            other_pos_nxt = '0;
          end else begin
            // The position counter and the reported index both saturate.
            if (other_pos_r != '1) begin
              other_pos_nxt = other_pos_r + POS_W'(1);
            end
            safe_nxt = (other_pos_r == '1) ? other_pos_r : other_pos_r + POS_W'(1);
            pt_nxt   = wp_in;
            vid_nxt  = in_item.vehicle_id;
            // An own path of fewer than two waypoints has nothing to scan.
            if (own_count_r >= CNT_W'(2)) begin
              state_nxt    = ST_SCAN;
              issue_on_nxt = 1'b1;
              k_nxt        = '0;
              last_idx_nxt = IDX_W'(own_count_r - CNT_W'(2));
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (state_r == ST_SCAN) begin
      if (issue_on_r) begin
        mem_re = 1'b1;
        k_nxt  = k_r + IDX_W'(1);
        if (k_r == last_idx_r) begin
          issue_on_nxt = 1'b0;
        end
      end
      if (dist_vld) begin
        if (dist_hit) begin
          out_strobe_nxt                = 1'b1;
          out_item_nxt.own_index        = IDX_OUT_W'(dist_idx);
          out_item_nxt.other_vehicle    = vid_r;
          out_item_nxt.other_safe_index = safe_r;
          state_nxt                     = ST_IDLE;
          issue_on_nxt                  = 1'b0;
          flush                         = 1'b1;
        end else if (dist_idx == last_idx_r) begin
          state_nxt = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      own_count_r  <= '0;
      other_pos_r  <= '0;
      r2_r         <= '0;
      issue_on_r   <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      own_count_r  <= own_count_nxt;
      other_pos_r  <= other_pos_nxt;
      issue_on_r   <= issue_on_nxt;
      rd_vld_r     <= mem_re & ~flush;
      out_strobe_r <= out_strobe_nxt;
      // The register holds the squared radius so the compare is exact.
      if (cfg_valid && cfg_ready) begin
        r2_r <= R2_W'(cfg_data) * R2_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    last_idx_r <= last_idx_nxt;
    rd_idx_r   <= k_r;
    out_item_r <= out_item_nxt;
    pt_r       <= pt_nxt;
    vid_r      <= vid_nxt;
    safe_r     <= safe_nxt;
  end

  ppcs_wp_mem #(
    .DEPTH (MAX_WAYPOINTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (own_count_r[IDX_W-1:0]),
    .wdata (wp_in),
    .re    (mem_re),
    .raddr (k_r),
    .rdata (mem_rdata)
  );

  ppcs_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (flush),
    .in_vld  (rd_vld_r),
    .in_idx  (rd_idx_r),
    .in_a    (mem_rdata),
    .in_b    (pt_r),
    .r2      (r2_r),
    .out_vld (dist_vld),
    .out_hit (dist_hit),
    .out_idx (dist_idx)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // A result only ever comes out of a scan.
  `ASSERT_IMP(a_strobe_after_scan, clk, rst_n, out_strobe_r,
              $past(state_r == ST_SCAN), "result strobe without a preceding scan")
  // A scan only runs over an own path of at least two waypoints.
  `ASSERT_IMP(a_scan_needs_path, clk, rst_n, state_r == ST_SCAN,
              own_count_r >= CNT_W'(2), "scan with a short own path")
  // Reads are never issued past the last scanned own waypoint.
  `ASSERT_IMP(a_issue_in_range, clk, rst_n, issue_on_r, k_r <= last_idx_r,
              "read issued beyond the scan range")
  // A check item with nothing to scan leaves the block idle.
  `ASSERT_NXT(a_no_scan_short, clk, rst_n,
              accept && in_item.mode == MODE_CHECK &&
              (in_item.path_end || own_count_r < CNT_W'(2)),
              state_r == ST_IDLE, "scan started for an item with nothing to scan")

endmodule

`default_nettype wire

// File: rtl/ppcs_wp_mem.sv
// ----------------------------------------------------------------------------
// ppcs_wp_mem
// Own waypoint store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcs_wp_mem #(
  parameter int DEPTH  = ppcs_pkg::MAX_WAYPOINTS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire ppcs_pkg::ppcs_wp_t wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output ppcs_pkg::ppcs_wp_t     rdata
);
  import ppcs_pkg::*;

  ppcs_wp_t mem [DEPTH];
  ppcs_wp_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/ppcs_dist.sv
// ----------------------------------------------------------------------------
// ppcs_dist
// Three-stage squared distance unit: differences, squares, then the sum is
// compared against the squared radius. One waypoint pair enters per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcs_dist #(
  parameter int IDX_W = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       flush,
  input  wire logic                       in_vld,
  input  wire logic [IDX_W-1:0]           in_idx,
  input  wire ppcs_pkg::ppcs_wp_t         in_a,
  input  wire ppcs_pkg::ppcs_wp_t         in_b,
  input  wire logic [ppcs_pkg::R2_W-1:0]  r2,
  output logic                            out_vld,
  output logic                            out_hit,
  output logic [IDX_W-1:0]                out_idx
);
  import ppcs_pkg::*;

  function automatic logic [SQ_W-1:0] sq_abs(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] mag;
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

  logic                     s1_vld_r, s2_vld_r, s3_vld_r;
  logic [IDX_W-1:0]         s1_idx_r, s2_idx_r, s3_idx_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [SQ_W-1:0]          sx_r, sy_r, sz_r;
  logic                     hit_r;
  logic [SUM_W-1:0]         sum;

  assign sum = SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld & ~flush;
      s2_vld_r <= s1_vld_r & ~flush;
      s3_vld_r <= s2_vld_r & ~flush;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= in_idx;
    dx_r     <= DIFF_W'(in_a.x) - DIFF_W'(in_b.x);
    dy_r     <= DIFF_W'(in_a.y) - DIFF_W'(in_b.y);
    dz_r     <= DIFF_W'(in_a.z) - DIFF_W'(in_b.z);
    s2_idx_r <= s1_idx_r;
    sx_r     <= sq_abs(dx_r);
    sy_r     <= sq_abs(dy_r);
    sz_r     <= sq_abs(dz_r);
    s3_idx_r <= s2_idx_r;
    hit_r    <= (sum < SUM_W'(r2));
  end

  assign out_vld = s3_vld_r;
  assign out_hit = hit_r;
  assign out_idx = s3_idx_r;

endmodule

`default_nettype wire
